// ----- rtl/lsbx_pkg.sv -----
package lsbx_pkg;

  // Parser phases of the back end (the header skip lives in the front end)
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_PWLEN,
    PH_PW,
    PH_EXTLEN,
    PH_EXT,
    PH_SIZE,
    PH_DATA,
    PH_IDLE
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_EXT       = 3'd0,
    KIND_SIZE      = 3'd1,
    KIND_DATA      = 3'd2,
    KIND_MAGIC_BAD = 3'd3,
    KIND_PW_BAD    = 3'd4
  } kind_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAGIC   = 3'd0;
  localparam logic [2:0] CFG_PW_LEN  = 3'd1;
  localparam logic [2:0] CFG_PW_LOW  = 3'd2;
  localparam logic [2:0] CFG_PW_MID  = 3'd3;
  localparam logic [2:0] CFG_PW_HIGH = 3'd4;

  localparam logic [4:0] MAX_PASSWORD_CHARS = 5'd24;

  // Field widths in bits, minus one (last bit index of a field)
  localparam logic [4:0] MAGIC_LAST_BIT = 5'd15;
  localparam logic [4:0] WORD_LAST_BIT  = 5'd31;
  localparam logic [4:0] CHAR_LAST_BIT  = 5'd7;

  typedef struct packed {
    logic [15:0] magic;
    logic [4:0]  pw_len;
    logic [63:0] pw_low;
    logic [63:0] pw_mid;
    logic [63:0] pw_high;
  } cfg_t;

  // One data bit handed from the front end to the back end
  typedef struct packed {
    logic start;    // first data bit of a new image
    logic bit_val;
  } bit_item_t;

  typedef struct packed {
    logic      push;
    bit_item_t item;
  } q_wr_t;

endpackage

// ----- rtl/lsbx_ifs.sv -----
interface lsbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cover_byte;
  logic       first_byte;

  modport source (output valid, output cover_byte, output first_byte, input ready);
  modport sink   (input valid, input cover_byte, input first_byte, output ready);
endinterface

interface lsbx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ----- rtl/lsbx_front.sv -----
module lsbx_front
  import lsbx_pkg::*;
#(
  parameter int HEADER_BYTES = 54
) (
  input  logic        clk,
  input  logic        rst_n,
  lsbx_in_if.sink     in_ch,
  input  logic        q_full,
  output q_wr_t       q_wr
);

  localparam int  HW      = (HEADER_BYTES < 2) ? 1 : $clog2(HEADER_BYTES + 1);
  localparam logic NO_HDR = (HEADER_BYTES == 0);

  logic [HW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic          hdr_done_r, hdr_done_nxt;
  logic          pend_r, pend_nxt;

  logic          accept;
  logic [HW-1:0] eff_cnt;
  logic          eff_done;
  logic          eff_pend;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A first-byte mark restarts the header count on this very byte
  assign eff_cnt  = in_ch.first_byte ? '0 : hdr_cnt_r;
  assign eff_done = in_ch.first_byte ? NO_HDR : hdr_done_r;
  assign eff_pend = in_ch.first_byte || pend_r;

  // Skip header bytes, forward data bits with a start flag
  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_done_nxt  = hdr_done_r;
    pend_nxt      = pend_r;
    q_wr.push     = 1'b0;
    q_wr.item.start   = eff_pend;
    q_wr.item.bit_val = in_ch.cover_byte[0];
    if (accept) begin
      if (!eff_done) begin
        hdr_cnt_nxt  = eff_cnt + 1'b1;
        hdr_done_nxt = (hdr_cnt_nxt == HW'(HEADER_BYTES));
        pend_nxt     = eff_pend;
      end else begin
        hdr_cnt_nxt  = eff_cnt;
        hdr_done_nxt = 1'b1;
        pend_nxt     = 1'b0;
        q_wr.push    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      hdr_done_r <= NO_HDR;
      pend_r     <= 1'b1;
    end else begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_done_r <= hdr_done_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

// ----- rtl/lsbx_queue.sv -----
module lsbx_queue
  import lsbx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_wr_t     q_wr,
  output logic      q_full,
  output logic      q_valid,
  output bit_item_t q_item,
  input  logic      q_pop
);

  localparam int PW = (QUEUE_DEPTH < 2) ? 1 : $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bit_item_t     mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_wr.push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_wr.push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/lsbx_back.sv -----
module lsbx_back
  import lsbx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  bit_item_t  q_item,
  output logic       q_pop,
  lsbx_out_if.source out_ch
);

  phase_t      phase_r, phase_nxt, ph_b;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt, bc_b;
  logic [31:0] acc_r, acc_nxt, acc_b;
  logic [31:0] items_r, items_nxt, items_b;
  logic [4:0]  ci_r, ci_nxt, ci_b;
  logic        mm_r, mm_nxt, mm_b;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_value_r;
  logic        out_last_r;

  logic        restart;
  logic        active;
  logic [31:0] v;
  logic [4:0]  last_bit;
  logic        field_done;
  logic        magic_bad;
  logic        pwlen_bad;
  logic [4:0]  ci_inc;
  logic        pw_end;
  logic        mm_new;
  logic        items_one;

  logic        res_valid;
  kind_t       res_kind;
  logic [31:0] res_value;
  logic        res_last;

  // Expected password character at a given index
  function automatic logic [7:0] pw_char(input cfg_t c, input logic [4:0] idx);
    logic [63:0] word;
    case (idx[4:3])
      2'd0:    word = c.pw_low;
      2'd1:    word = c.pw_mid;
      default: word = c.pw_high;
    endcase
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

  // Take a bit when the output register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // Start of a new image clears the parse state
  assign restart = q_pop && q_item.start;
  assign ph_b    = restart ? PH_MAGIC : phase_r;
  assign bc_b    = restart ? '0 : bit_cnt_r;
  assign acc_b   = restart ? '0 : acc_r;
  assign items_b = restart ? '0 : items_r;
  assign ci_b    = restart ? '0 : ci_r;
  assign mm_b    = restart ? 1'b0 : mm_r;

  assign active = q_pop && (ph_b != PH_IDLE);
  assign v      = {acc_b[30:0], q_item.bit_val};

  always_comb begin
    case (ph_b)
      PH_MAGIC:                     last_bit = MAGIC_LAST_BIT;
      PH_PWLEN, PH_EXTLEN, PH_SIZE: last_bit = WORD_LAST_BIT;
      default:                      last_bit = CHAR_LAST_BIT;
    endcase
  end

  assign field_done = (bc_b == last_bit);
  assign magic_bad  = (v[15:0] != cfg.magic);
  assign pwlen_bad  = (cfg.pw_len > MAX_PASSWORD_CHARS) || (v != {27'd0, cfg.pw_len});
  assign ci_inc     = ci_b + 1'b1;
  assign pw_end     = (ci_inc >= cfg.pw_len);
  assign mm_new     = mm_b || (v[7:0] != pw_char(cfg, ci_b));
  assign items_one  = (items_b == 32'd1);

  // Next parse state
  always_comb begin
    phase_nxt   = ph_b;
    bit_cnt_nxt = bc_b;
    acc_nxt     = acc_b;
    items_nxt   = items_b;
    ci_nxt      = ci_b;
    mm_nxt      = mm_b;
    if (active) begin
      acc_nxt     = v;
      bit_cnt_nxt = bc_b + 1'b1;
      if (field_done) begin
        acc_nxt     = '0;
        bit_cnt_nxt = '0;
        case (ph_b)
          PH_MAGIC: begin
            phase_nxt = magic_bad ? PH_IDLE : PH_PWLEN;
          end
          PH_PWLEN: begin
            ci_nxt = '0;
            mm_nxt = 1'b0;
            if (pwlen_bad) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = (v == '0) ? PH_EXTLEN : PH_PW;
            end
          end
          PH_PW: begin
            mm_nxt = mm_new;
            ci_nxt = ci_inc;
            if (pw_end) begin
              phase_nxt = mm_new ? PH_IDLE : PH_EXTLEN;
            end
          end
          PH_EXTLEN: begin
            items_nxt = v;
            phase_nxt = (v == '0) ? PH_SIZE : PH_EXT;
          end
          PH_EXT: begin
            items_nxt = items_b - 1'b1;
            if (items_one) begin
              phase_nxt = PH_SIZE;
            end
          end
          PH_SIZE: begin
            items_nxt = v;
            phase_nxt = (v == '0) ? PH_IDLE : PH_DATA;
          end
          PH_DATA: begin
            items_nxt = items_b - 1'b1;
            if (items_one) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result caused by this bit
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_EXT;
    res_value = '0;
    res_last  = 1'b0;
    if (active && field_done) begin
      case (ph_b)
        PH_MAGIC: begin
          res_valid = magic_bad;
          res_kind  = KIND_MAGIC_BAD;
        end
        PH_PWLEN: begin
          res_valid = pwlen_bad;
          res_kind  = KIND_PW_BAD;
        end
        PH_PW: begin
          res_valid = pw_end && mm_new;
          res_kind  = KIND_PW_BAD;
        end
        PH_EXT: begin
          res_valid = 1'b1;
          res_kind  = KIND_EXT;
          res_value = {24'd0, v[7:0]};
        end
        PH_SIZE: begin
          res_valid = 1'b1;
          res_kind  = KIND_SIZE;
          res_value = v;
          res_last  = (v == '0);
        end
        PH_DATA: begin
          res_valid = 1'b1;
          res_kind  = KIND_DATA;
          res_value = {24'd0, v[7:0]};
          res_last  = items_one;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC;
      bit_cnt_r <= '0;
      acc_r     <= '0;
      items_r   <= '0;
      ci_r      <= '0;
      mm_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      acc_r     <= acc_nxt;
      items_r   <= items_nxt;
      ci_r      <= ci_nxt;
      mm_r      <= mm_nxt;
    end
  end

  // Output register: load on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_last_r  <= res_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

endmodule

// ----- rtl/lsb_stego_payload_extractor.sv -----
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   cover_byte[7:0], first_byte
// out_ch    out  valid/ready   kind[2:0], value[31:0], last
// cfg_*     in   cfg_we        cfg_index[2:0], cfg_wdata[63:0]
//
// One cover byte is taken per cycle while the bit queue is not full; a data bit
// waits in the bit queue, then its result in the output register. Throughput is
// one byte per cycle unless stalled, set by the single-bit shift in the parser.
// Synchronous active-low reset acts as the start of a new image; config regs clear.
// A stalled output holds the parser; the bit queue absorbs QUEUE_DEPTH bytes
// before in_ch.ready drops.
module lsb_stego_payload_extractor
  import lsbx_pkg::*;
#(
  parameter int HEADER_BYTES = 54,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  lsbx_in_if.sink     in_ch,
  lsbx_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  cfg_t      cfg_r;
  q_wr_t     q_wr;
  logic      q_full;
  logic      q_valid;
  bit_item_t q_item;
  logic      q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:   cfg_r.magic   <= cfg_wdata[15:0];
        CFG_PW_LEN:  cfg_r.pw_len  <= cfg_wdata[4:0];
        CFG_PW_LOW:  cfg_r.pw_low  <= cfg_wdata;
        CFG_PW_MID:  cfg_r.pw_mid  <= cfg_wdata;
        CFG_PW_HIGH: cfg_r.pw_high <= cfg_wdata;
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  lsbx_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  lsbx_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lsbx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A bit enters the queue only from an accepted item
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (in_ch.valid && in_ch.ready))
    else $error("bit queued without an accepted item");

  // The parser never pops an empty queue
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty bit queue");

  // A zero payload size closes the record
  a_zero_size_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_SIZE) && (out_ch.value == 32'd0))
      |-> out_ch.last)
    else $error("zero size result without last");

  // A new result appears only after a bit was taken from the queue
  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop))
    else $error("result without a parsed bit");

endmodule

// ----- bench/lsbx_extract_check.sv -----
module lsbx_extract_check
  import lsbx_pkg::*;
#(
  parameter int HEADER_BYTES = 54
) (
  input  logic        clk,
  input  logic        rst_n,
  lsbx_in_if          in_mon,
  lsbx_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          mismatch_count,
  output int          results_owed,
  output int          results_checked,
  output int          rejects_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } extract_t;

  // Register copy
  logic [15:0] magic_q;
  logic [4:0]  pw_len_q;
  logic [63:0] pw_low_q;
  logic [63:0] pw_mid_q;
  logic [63:0] pw_high_q;

  // Parser copy
  logic        in_header;
  logic [5:0]  hdr_cnt;
  phase_t      phase;
  logic [4:0]  bit_cnt;
  logic [31:0] acc;
  logic [31:0] left;
  logic [4:0]  char_idx;
  logic        pw_bad;

  extract_t expected_q[$];
  int fails;
  int checked;
  int rejects;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    fails++;
    if (fails <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what,
               got_v, want_v);
    end
  endtask

  task automatic restart_image();
    in_header = (HEADER_BYTES != 0);
    hdr_cnt   = '0;
    phase     = PH_MAGIC;
    bit_cnt   = '0;
    acc       = '0;
    left      = '0;
    char_idx  = '0;
    pw_bad    = 1'b0;
  endtask

  task automatic open_field(input phase_t ph);
    phase   = ph;
    bit_cnt = '0;
    acc     = '0;
  endtask

  function automatic logic [7:0] pw_char(input logic [4:0] idx);
    logic [63:0] w;
    if (idx < 5'd8) w = pw_low_q;
    else if (idx < 5'd16) w = pw_mid_q;
    else w = pw_high_q;
    return w[idx[2:0]*8 +: 8];
  endfunction

  // Skip the header, then shift a cover bit into the record parser; flag any result
  task automatic extract_step(input logic [7:0] cb, input logic fb, output logic got,
                              output extract_t res);
    int          need;
    logic [31:0] word;
    got = 1'b0;
    res = '0;
    if (fb) restart_image();
    if (in_header) begin
      hdr_cnt = hdr_cnt + 6'd1;
      if (int'(hdr_cnt) >= HEADER_BYTES) begin
        in_header = 1'b0;
        open_field(PH_MAGIC);
      end
      return;
    end
    if (phase == PH_IDLE) return;

    case (phase)
      PH_MAGIC: need = 16;
      PH_PWLEN, PH_EXTLEN, PH_SIZE: need = 32;
      default: need = 8;
    endcase
    acc = {acc[30:0], cb[0]};
    if (int'(bit_cnt) + 1 < need) begin
      bit_cnt = bit_cnt + 5'd1;
      return;
    end
    bit_cnt = '0;
    word    = acc;
    acc     = '0;

    case (phase)
      PH_MAGIC: begin
        if (word[15:0] != magic_q) begin
          phase = PH_IDLE;
          got   = 1'b1;
          res   = '{KIND_MAGIC_BAD, 32'd0, 1'b0};
        end else begin
          open_field(PH_PWLEN);
        end
      end
      PH_PWLEN: begin
        if (pw_len_q > MAX_PASSWORD_CHARS || word != 32'(pw_len_q)) begin
          phase = PH_IDLE;
          got   = 1'b1;
          res   = '{KIND_PW_BAD, 32'd0, 1'b0};
        end else begin
          char_idx = '0;
          pw_bad   = 1'b0;
          open_field(word == 32'd0 ? PH_EXTLEN : PH_PW);
        end
      end
      PH_PW: begin
        if (word[7:0] != pw_char(char_idx)) pw_bad = 1'b1;
        char_idx = char_idx + 5'd1;
        if (char_idx >= pw_len_q) begin
          if (pw_bad) begin
            phase = PH_IDLE;
            got   = 1'b1;
            res   = '{KIND_PW_BAD, 32'd0, 1'b0};
          end else begin
            open_field(PH_EXTLEN);
          end
        end
      end
      PH_EXTLEN: begin
        left = word;
        open_field(word == 32'd0 ? PH_SIZE : PH_EXT);
      end
      PH_EXT: begin
        left = left - 32'd1;
        if (left == 32'd0) open_field(PH_SIZE);
        got = 1'b1;
        res = '{KIND_EXT, 32'(word[7:0]), 1'b0};
      end
      PH_SIZE: begin
        left = word;
        open_field(word == 32'd0 ? PH_IDLE : PH_DATA);
        got = 1'b1;
        res = '{KIND_SIZE, word, word == 32'd0};
      end
      PH_DATA: begin
        left = left - 32'd1;
        if (left == 32'd0) phase = PH_IDLE;
        got = 1'b1;
        res = '{KIND_DATA, 32'(word[7:0]), left == 32'd0};
      end
      default: ;
    endcase
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    extract_t want;
    extract_t res;
    logic     got;
    if (!rst_n) begin
      magic_q   = '0;
      pw_len_q  = '0;
      pw_low_q  = '0;
      pw_mid_q  = '0;
      pw_high_q = '0;
      restart_image();
      expected_q.delete();
    end else begin
      // Compare a delivered item with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, kind", 32'(out_mon.kind), 32'd0);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.kind == KIND_MAGIC_BAD || want.kind == KIND_PW_BAD) rejects++;
          if (out_mon.kind != want.kind)
            report_mismatch("kind", 32'(out_mon.kind), 32'(want.kind));
          if (out_mon.value != want.value)
            report_mismatch("value", out_mon.value, want.value);
          if (out_mon.last != want.last)
            report_mismatch("last", 32'(out_mon.last), 32'(want.last));
        end
      end
      // Predict from an accepted cover byte
      if (in_mon.valid && in_mon.ready) begin
        extract_step(in_mon.cover_byte, in_mon.first_byte, got, res);
        if (got) expected_q.push_back(res);
      end
      // Track register writes, masked to their widths
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:   magic_q   = cfg_wdata[15:0];
          CFG_PW_LEN:  pw_len_q  = cfg_wdata[4:0];
          CFG_PW_LOW:  pw_low_q  = cfg_wdata;
          CFG_PW_MID:  pw_mid_q  = cfg_wdata;
          CFG_PW_HIGH: pw_high_q = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatch_count  <= fails;
    results_owed    <= expected_q.size();
    results_checked <= checked;
    rejects_checked <= rejects;
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import lsbx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HEADER_BYTES  = 54;
  localparam int         LAST_GAP      = 17;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         PHASE_BYTES   = 320;
  localparam int         RAND_PHASES   = 5;
  localparam logic [2:0] CFG_UNUSED    = 3'd5;
  localparam logic [1:0] PAD_RANDOM    = 2'd0;
  localparam logic [1:0] PAD_ZERO      = 2'd1;
  localparam logic [1:0] PAD_ONE       = 2'd2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  int mismatch_count;
  int results_owed;
  int results_checked;
  int rejects_checked;

  lsbx_in_if  in_ch();
  lsbx_out_if out_ch();

  lsb_stego_payload_extractor #(
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  lsbx_extract_check #(
    .HEADER_BYTES(HEADER_BYTES)
  ) extract_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .results_checked(results_checked),
    .rejects_checked(rejects_checked)
  );

  always #1 clk = ~clk;

  // Stimulus state
  logic       tx_calm = 1'b0;
  logic       rx_calm = 1'b0;
  logic       hold_req = 1'b0;
  logic [1:0] pad_mode = PAD_RANDOM;
  logic       bits_q[$];
  int         bytes_sent = 0;
  int         images = 0;

  // Copy of the programmed registers, used to build matching records
  logic [15:0] magic_cfg;
  logic [4:0]  pw_len_cfg;
  logic [7:0]  pw_chars[24];

  function automatic int draw_wait(input logic calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, LAST_GAP);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [6:0] pad_bits();
    case (pad_mode)
      PAD_ZERO: return '0;
      PAD_ONE:  return '1;
      default:  return 7'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fb);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cover_byte <= b;
    in_ch.first_byte <= fb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send a header of hdr_n bytes, then one cover byte per queued bit
  task automatic send_image(input int hdr_n);
    logic b;
    for (int i = 0; i < hdr_n; i++) send_byte({pad_bits(), 1'($urandom)}, i == 0);
    while (bits_q.size() > 0) begin
      b = bits_q.pop_front();
      send_byte({pad_bits(), b}, 1'b0);
    end
    images++;
  endtask

  task automatic put_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) bits_q.push_back(v[i]);
  endtask

  // Lay out a record; bad names the password character to corrupt, -1 for none
  task automatic build_record(input logic [15:0] mag, input logic [31:0] pwf,
                              input int nchars, input int bad, input logic [31:0] extl,
                              input int exts, input logic [31:0] sz, input int datas);
    logic [7:0] c;
    bits_q.delete();
    put_field(32'(mag), 16);
    put_field(pwf, 32);
    for (int i = 0; i < nchars; i++) begin
      c = pw_chars[i];
      if (i == bad) c = c ^ 8'(1 << $urandom_range(0, 7));
      put_field(32'(c), 8);
    end
    put_field(extl, 32);
    for (int i = 0; i < exts; i++) put_field(32'($urandom_range(0, 255)), 8);
    put_field(sz, 32);
    for (int i = 0; i < datas; i++) put_field(32'($urandom_range(0, 255)), 8);
  endtask

  // Write every register, plus a stray index; random bits above magic and length
  task automatic program_regs(input logic [15:0] mag, input logic [4:0] len,
                              input logic [63:0] lo, input logic [63:0] mi,
                              input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= {$urandom, 16'($urandom), mag};
    @(posedge clk);
    cfg_index <= CFG_UNUSED + 3'($urandom_range(0, 2));
    cfg_wdata <= rand64();
    @(posedge clk);
    cfg_index <= CFG_PW_LEN;
    cfg_wdata <= {$urandom, 27'($urandom), len};
    @(posedge clk);
    cfg_index <= CFG_PW_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_PW_MID;
    cfg_wdata <= mi;
    @(posedge clk);
    cfg_index <= CFG_PW_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    magic_cfg  = mag;
    pw_len_cfg = len;
    for (int i = 0; i < 8; i++) begin
      pw_chars[i]      = lo[8*i +: 8];
      pw_chars[8 + i]  = mi[8*i +: 8];
      pw_chars[16 + i] = hi[8*i +: 8];
    end
  endtask

  // Stop offering, wait for every owed result, then let the parser settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed records with random content; some broken ones and noise
  task automatic random_image();
    int          pick;
    int          nchars;
    int          bad;
    int          exts;
    int          datas;
    int          hdr_n;
    int          keep;
    logic [15:0] mag;
    logic [31:0] pwf;
    logic [31:0] extl;
    logic [31:0] sz;
    pick   = $urandom_range(0, 99);
    mag    = magic_cfg;
    pwf    = 32'(pw_len_cfg);
    nchars = (pw_len_cfg > MAX_PASSWORD_CHARS) ? 0 : int'(pw_len_cfg);
    bad    = -1;
    extl   = $urandom_range(0, 4);
    exts   = int'(extl);
    sz     = $urandom_range(0, 8);
    datas  = int'(sz);
    hdr_n  = HEADER_BYTES;
    if (pick < 8) begin
      mag = mag ^ 16'(1 << $urandom_range(0, 15));
    end else if (pick < 16) begin
      pwf    = (pick < 12) ? $urandom : pwf ^ 32'(1 << $urandom_range(0, 4));
      nchars = 0;
    end else if (pick < 24 && nchars > 0) begin
      bad = $urandom_range(0, nchars - 1);
    end else if (pick < 28) begin
      extl = {1'b1, 31'($urandom)};
      exts = $urandom_range(1, 3);
    end else if (pick < 32) begin
      sz    = {1'b1, 31'($urandom)};
      datas = $urandom_range(0, 3);
    end
    build_record(mag, pwf, nchars, bad, extl, exts, sz, datas);
    if (pick >= 32 && pick < 38) begin
      // Cut the record short; the next image restarts the parser
      keep = $urandom_range(0, bits_q.size() - 1);
      while (bits_q.size() > keep) void'(bits_q.pop_back());
    end else if (pick >= 38 && pick < 42) begin
      bits_q.delete();
      hdr_n = $urandom_range(1, HEADER_BYTES - 1);
    end else if (pick >= 42 && pick < 48) begin
      bits_q.delete();
      repeat ($urandom_range(24, 120)) bits_q.push_back(1'($urandom));
    end
    // Trailing bytes after the record end are dropped
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) bits_q.push_back(1'($urandom));
    end
    if (pick >= 95) hold_req = 1'b1;
    tx_calm  = ($urandom_range(0, 3) == 0);
    pad_mode = PAD_RANDOM;
    send_image(hdr_n);
  endtask

  // Result side: random stalls, calm stretches, and long hold-offs on request
  initial begin
    int stall;
    int served;
    served = 0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = draw_wait(rx_calm);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      served++;
      if (served % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    end
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.cover_byte <= 8'h00;
    in_ch.first_byte <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_MAGIC;
    cfg_wdata        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records under a three-character password
    program_regs(16'hC3A5, 5'd3, rand64(), rand64(), rand64());

    // Good record, all-ones padding, back-to-back bytes, receiver holds off
    pad_mode = PAD_ONE;
    tx_calm  = 1'b1;
    hold_req = 1'b1;
    build_record(magic_cfg, 32'd3, 3, -1, 32'd2, 2, 32'd12, 12);
    send_image(HEADER_BYTES);

    // Wrong magic word, all-zero padding
    pad_mode = PAD_ZERO;
    tx_calm  = 1'b0;
    build_record(magic_cfg ^ 16'h8000, 32'd3, 3, -1, 32'd0, 0, 32'd1, 1);
    send_image(HEADER_BYTES);

    // Password length field off by one
    pad_mode = PAD_RANDOM;
    build_record(magic_cfg, 32'd4, 0, -1, 32'd0, 0, 32'd1, 1);
    send_image(HEADER_BYTES);

    // Last password character wrong
    build_record(magic_cfg, 32'd3, 3, 2, 32'd1, 1, 32'd1, 1);
    send_image(HEADER_BYTES);

    // Empty extension and zero payload, then junk that is dropped
    build_record(magic_cfg, 32'd3, 3, -1, 32'd0, 0, 32'd0, 0);
    repeat (16) bits_q.push_back(1'($urandom));
    send_image(HEADER_BYTES);

    // Huge extension length, cut off by the next image
    build_record(magic_cfg, 32'd3, 3, -1, 32'hFFFF_FFFF, 2, 32'd0, 0);
    send_image(HEADER_BYTES);

    // Huge payload size, cut off by the next image
    build_record(magic_cfg, 32'd3, 3, -1, 32'd1, 1, 32'hFFFF_FFFF, 3);
    send_image(HEADER_BYTES);

    // Single payload byte carries last
    build_record(magic_cfg, 32'd3, 3, -1, 32'd0, 0, 32'd1, 1);
    send_image(HEADER_BYTES);

    // Image restarted inside the header
    bits_q.delete();
    send_image(10);
    build_record(magic_cfg, 32'd3, 3, -1, 32'd2, 2, 32'd2, 2);
    send_image(HEADER_BYTES);
    drain();

    // Random records under several register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      int start;
      case (p)
        0: program_regs(16'h0000, 5'd0, rand64(), rand64(), rand64());
        1: program_regs(16'hFFFF, MAX_PASSWORD_CHARS, '1, '1, '1);
        2: program_regs(16'($urandom), 5'($urandom_range(25, 31)), rand64(), rand64(),
                        rand64());
        3: program_regs(16'($urandom), 5'($urandom_range(1, 23)), rand64(), '0, rand64());
        default: program_regs(16'($urandom), 5'($urandom_range(1, 8)), rand64(), rand64(),
                              rand64());
      endcase
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_image();
      drain();
    end

    $display("summary: %0d images, %0d cover bytes, %0d results checked (%0d rejects)",
             images, bytes_sent, results_checked, rejects_checked);
    $display("summary: %0d register settings, password lengths from 0 to 31", RAND_PHASES + 1);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
